@@ rtl/spq_pkg.sv @@
// Shared constants and types for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int FRONT_BITS = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IN_W       = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_W      = ((FRONT_BITS + CNT_W + 2 + 7) / 8) * 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

@@ rtl/spq_ctrl.sv @@
// Handshake controller for the sorted priority queue.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_accept;

    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_out_valid   = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/spq_datapath.sv @@
// Sorted shift row of entries with compare cells and the result register.
module spq_datapath
    import spq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic                  i_command,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic [FRONT_BITS-1:0] o_front_value,
    output logic [CNT_W-1:0]      o_entry_count,
    output logic                  o_is_empty,
    output logic                  o_error
);

    logic                  r_command;
    logic [VALUE_BITS-1:0] r_value;
    logic [VALUE_BITS-1:0] r_entries [DEPTH];
    logic [VALUE_BITS-1:0] n_entries [DEPTH];
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  n_error;
    logic [DEPTH-1:0]      w_lt;

    logic [FRONT_BITS-1:0] r_front;
    logic [CNT_W-1:0]      r_cnt_out;
    logic                  r_empty;
    logic                  r_error;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_lt[i] = (CNT_W'(i) < r_count) &&
                      ($signed(r_entries[i]) < $signed(r_value));
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
        end
        n_count = r_count;
        n_error = 1'b0;
        if (r_command == CMD_INSERT) begin
            if (r_count == CNT_W'(DEPTH)) begin
                n_error = 1'b1;
            end else begin
                if (!w_lt[0]) begin
                    n_entries[0] = r_value;
                end
                for (int i = 1; i < DEPTH; i++) begin
                    if (!w_lt[i]) begin
                        if (w_lt[i-1]) begin
                            n_entries[i] = r_value;
                        end else begin
                            n_entries[i] = r_entries[i-1];
                        end
                    end
                end
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (r_count == '0) begin
                n_error = 1'b1;
            end else begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    n_entries[i] = r_entries[i+1];
                end
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_command <= i_command;
            r_value   <= i_value;
        end
        if (i_cmd.execute) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entries[i] <= n_entries[i];
            end
            r_front   <= (n_count == '0) ? '0 : n_entries[0][FRONT_BITS-1:0];
            r_cnt_out <= n_count;
            r_empty   <= (n_count == '0);
            r_error   <= n_error;
        end
    end

    assign o_front_value = r_front;
    assign o_entry_count = r_cnt_out;
    assign o_is_empty    = r_empty;
    assign o_error       = r_error;

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: controller plus datapath.
//
// Bounded min-priority queue of 16 signed 32-bit keys kept in ascending order.
// Slave channel: one beat per command. tuser is the command (0 insert,
// 1 remove), tdata the key to insert (ignored on remove).
// Master channel: one beat per command with the state after it: front key
// (0 when empty), entry count, empty flag, and an error flag for a remove on
// an empty queue or an insert on a full queue (the key is then dropped).
// Equal keys are served last in, first out.
// The command beat is captured into the datapath; the controller's execute
// state then updates the row and the result register, which drives tvalid.
// No new command is taken before the current one has executed (the
// controller's capture/execute pair); all compare cells shift the row at once.
// The next command is taken while a result waits, as long as the receiver
// takes that result in the same cycle; a stalled receiver holds the result
// and blocks new commands.
// Reset (synchronous, active low) empties the queue and drops any result.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,  // value
    input  logic             i_s_tuser,  // command
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata   // front_value, entry_count, is_empty, error, zero pad
);

    t_dp_cmd               w_cmd;
    logic [FRONT_BITS-1:0] w_front;
    logic [CNT_W-1:0]      w_count;
    logic                  w_empty;
    logic                  w_error;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    spq_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_command     (i_s_tuser),
        .i_value       (i_s_tdata[VALUE_BITS-1:0]),
        .o_front_value (w_front),
        .o_entry_count (w_count),
        .o_is_empty    (w_empty),
        .o_error       (w_error)
    );

    assign o_m_tdata = OUT_W'({w_error, w_empty, w_count, w_front});

endmodule

@@ tb/sv/tb_sorted_priority_queue.sv @@
// Self-checking testbench for the sorted priority queue with a shadow row predictor.
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int CNT_LSB   = FRONT_BITS;
    localparam int EMPTY_BIT = FRONT_BITS + CNT_W;
    localparam int ERR_BIT   = EMPTY_BIT + 1;

    typedef struct packed {
        logic [FRONT_BITS-1:0] front;
        logic [CNT_W-1:0]      count;
        logic                  empty;
        logic                  err;
    } t_queue_status;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_valid;
    logic             s_ready;
    logic [IN_W-1:0]  s_data;
    logic             s_user;
    logic             m_valid;
    logic             m_ready;
    logic [OUT_W-1:0] m_data;

    logic signed [VALUE_BITS-1:0] shadow_row [DEPTH];
    int                           shadow_count;
    t_queue_status                expected_status [$];

    int fail_count;
    int insert_count;
    int remove_count;
    int full_reject_count;
    int empty_reject_count;
    int checked_count;
    int max_seen_count;
    int burst_left;
    bit steady;

    sorted_priority_queue u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    // receiver stall pattern, switches between four modes at random
    initial begin
        int mode;
        int mode_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            case (mode)
                0: begin
                    m_ready = 1'b1;
                end
                1: begin
                    m_ready = $urandom_range(0, 1);
                end
                2: begin
                    m_ready = ($urandom_range(0, 7) == 0);
                end
                default: begin
                    m_ready = (phase % 3 != 0);
                end
            endcase
        end
    end

    function automatic t_queue_status apply_to_shadow(input logic cmd,
                                                      input logic signed [VALUE_BITS-1:0] key);
        t_queue_status st;
        int            pos;
        int            i;
        st.err = 1'b0;
        if (cmd == CMD_INSERT) begin
            if (shadow_count >= DEPTH) begin
                st.err = 1'b1;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow_row[pos] < key)
                    pos++;
                for (i = shadow_count; i > pos; i--)
                    shadow_row[i] = shadow_row[i-1];
                shadow_row[pos] = key;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                st.err = 1'b1;
            end else begin
                for (i = 0; i + 1 < shadow_count; i++)
                    shadow_row[i] = shadow_row[i+1];
                shadow_count--;
            end
        end
        st.front = (shadow_count == 0) ? '0 : shadow_row[0];
        st.count = shadow_count[CNT_W-1:0];
        st.empty = (shadow_count == 0);
        return st;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_queue_status exp_st;
        t_queue_status got;
        if (i_rst_n && m_valid && m_ready) begin
            got.front = m_data[FRONT_BITS-1:0];
            got.count = m_data[CNT_LSB +: CNT_W];
            got.empty = m_data[EMPTY_BIT];
            got.err   = m_data[ERR_BIT];
            if (expected_status.size() == 0) begin
                $error("unexpected result beat: front %0d count %0d",
                       $signed(got.front), got.count);
                fail_count++;
            end else begin
                exp_st = expected_status.pop_front();
                checked_count++;
                if (got.front !== exp_st.front) begin
                    $error("front_value: expected %0d, got %0d",
                           $signed(exp_st.front), $signed(got.front));
                    fail_count++;
                end
                if (got.count !== exp_st.count) begin
                    $error("entry_count: expected %0d, got %0d", exp_st.count, got.count);
                    fail_count++;
                end
                if (got.empty !== exp_st.empty) begin
                    $error("is_empty: expected %0b, got %0b", exp_st.empty, got.empty);
                    fail_count++;
                end
                if (got.err !== exp_st.err) begin
                    $error("error: expected %0b, got %0b", exp_st.err, got.err);
                    fail_count++;
                end
            end
        end
    end

    task automatic idle_gap();
        int gap;
        gap = $urandom_range(1, 6);
        @(negedge i_clk);
        s_valid = 1'b0;
        repeat (gap - 1) @(negedge i_clk);
    endtask

    task automatic send_command(input logic cmd, input logic [VALUE_BITS-1:0] key);
        t_queue_status st;
        if (!steady && burst_left <= 0) begin
            idle_gap();
            burst_left = $urandom_range(1, 20);
        end
        @(negedge i_clk);
        s_valid = 1'b1;
        s_user  = cmd;
        s_data  = '0;
        s_data[VALUE_BITS-1:0] = key;
        do @(posedge i_clk); while (!s_ready);
        st = apply_to_shadow(cmd, key);
        expected_status.push_back(st);
        burst_left--;
        if (cmd == CMD_INSERT) begin
            insert_count++;
            if (st.err) full_reject_count++;
        end else begin
            remove_count++;
            if (st.err) empty_reject_count++;
        end
        if (shadow_count > max_seen_count) max_seen_count = shadow_count;
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        s_valid = 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_key();
        logic [VALUE_BITS-1:0] k;
        case ($urandom_range(0, 9))
            0: k = {1'b0, {(VALUE_BITS-1){1'b1}}};
            1: k = {1'b1, {(VALUE_BITS-1){1'b0}}};
            2: k = {1'b1, {(VALUE_BITS-2){1'b0}}, 1'b1};
            3, 4: k = $urandom_range(0, 8) - 4;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    task automatic run_mix(input int n_items, input int insert_pct, input bit tight_keys);
        logic [VALUE_BITS-1:0] k;
        repeat (n_items) begin
            k = tight_keys ? VALUE_BITS'($urandom_range(0, 4) - 2) : pick_key();
            if ($urandom_range(0, 99) < insert_pct)
                send_command(CMD_INSERT, k);
            else
                send_command(CMD_REMOVE, $urandom);
        end
    endtask

    task automatic test_remove_on_empty();
        send_command(CMD_REMOVE, '1);
        send_command(CMD_REMOVE, '0);
    endtask

    task automatic test_fill_with_extremes();
        logic [VALUE_BITS-1:0] keys [16];
        keys = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
                 32'h8000_0001, 32'h7FFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA,
                 32'h1, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0, 32'h1234_5678};
        foreach (keys[i])
            send_command(CMD_INSERT, keys[i]);
        // queue is full now, both keys must be dropped
        send_command(CMD_INSERT, 32'h8000_0000);
        send_command(CMD_INSERT, 32'h0);
    endtask

    task automatic test_partial_drain();
        repeat (4) send_command(CMD_REMOVE, $urandom);
    endtask

    task automatic test_random_occupancy_walk();
        int bias [5];
        bias = '{10, 30, 50, 70, 90};
        repeat (20)
            run_mix(35, bias[$urandom_range(0, 4)], 1'b0);
    endtask

    task automatic test_tied_keys();
        run_mix(100, 75, 1'b1);
        run_mix(100, 35, 1'b1);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        run_mix(75, 80, 1'b0);
        run_mix(75, 25, 1'b0);
        steady = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        s_user  = 1'b0;
        steady  = 1'b0;
        burst_left = 0;
        shadow_count = 0;
        fail_count = 0;
        insert_count = 0;
        remove_count = 0;
        full_reject_count = 0;
        empty_reject_count = 0;
        checked_count = 0;
        max_seen_count = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_remove_on_empty();
        test_fill_with_extremes();
        test_partial_drain();
        pause_until_drained();
        test_random_occupancy_walk();
        pause_until_drained();
        test_tied_keys();
        test_back_to_back();
        pause_until_drained();
        repeat (8) @(posedge i_clk);

        $display("tb: %0d commands checked: %0d inserts (%0d refused when full), %0d removes",
                 checked_count, insert_count, full_reject_count, remove_count);
        $display("tb: %0d removes on an empty queue, peak occupancy %0d of %0d",
                 empty_reject_count, max_seen_count, DEPTH);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue.sv
tb/sv/tb_sorted_priority_queue.sv
